// File: rtl/core/tsp_pkg.sv
package tsp_pkg;

  localparam int GRID_SIZE_DEF = 32;

  // fixed field widths of the command and result words
  localparam int KIND_W    = 3;
  localparam int DIST_W    = 8;
  localparam int QRY_W     = 5;
  localparam int POS_OUT_W = 5;
  localparam int HDG_W     = 2;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [KIND_W-1:0] {
    K_PEN_UP     = 3'd0,
    K_PEN_DOWN   = 3'd1,
    K_FACE_RIGHT = 3'd2,
    K_FACE_LEFT  = 3'd3,
    K_FACE_UP    = 3'd4,
    K_FACE_DOWN  = 3'd5,
    K_MOVE       = 3'd6,
    K_READ       = 3'd7
  } kind_t;

  typedef enum logic [HDG_W-1:0] {
    H_RIGHT = 2'd0,
    H_LEFT  = 2'd1,
    H_UP    = 2'd2,
    H_DOWN  = 2'd3
  } heading_t;

  typedef enum logic [1:0] {
    OP_PEN,
    OP_FACE,
    OP_MOVE,
    OP_READ
  } op_t;

  // decoded command as it sits in the queue
  typedef struct packed {
    op_t                op;
    logic               pen;
    heading_t           hdg;
    logic [DIST_W-1:0]  mv_dist;
    logic               q_ok;
    logic [QRY_W-1:0]   q_row;
    logic [QRY_W-1:0]   q_col;
  } cmd_op_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MARK,
    BK_DRAIN,
    BK_READ
  } bk_state_t;

  typedef struct packed {
    logic pop;
    logic busy;
  } bk_stat_t;

endpackage

// File: rtl/core/tsp_cmd_if.sv
interface tsp_cmd_if;
  import tsp_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [DIST_W-1:0] distance;
  logic [QRY_W-1:0]  query_row;
  logic [QRY_W-1:0]  query_col;

  modport source (output valid, kind, distance, query_row, query_col, input ready);
  modport sink   (input valid, kind, distance, query_row, query_col, output ready);
endinterface

// File: rtl/core/tsp_res_if.sv
interface tsp_res_if;
  import tsp_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [POS_OUT_W-1:0] cursor_row_out;
  logic [POS_OUT_W-1:0] cursor_col_out;
  logic                 pen_is_down;
  logic [HDG_W-1:0]     heading_out;
  logic                 cell_bit;

  modport source (output valid, cursor_row_out, cursor_col_out, pen_is_down, heading_out,
                  cell_bit, input ready);
  modport sink   (input valid, cursor_row_out, cursor_col_out, pen_is_down, heading_out,
                  cell_bit, output ready);
endinterface

// File: rtl/core/tsp_ram.sv
module tsp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/tsp_front.sv
module tsp_front #(
  parameter int GRID_SIZE = tsp_pkg::GRID_SIZE_DEF
) (
  tsp_cmd_if.sink          in_cmd,
  input  logic             q_full,
  output logic             q_push,
  output tsp_pkg::cmd_op_t q_op
);
  import tsp_pkg::*;

  assign in_cmd.ready = !q_full;
  assign q_push       = in_cmd.valid && !q_full;

  always_comb begin
    q_op         = '0;
    q_op.mv_dist = in_cmd.distance;
    q_op.q_row   = in_cmd.query_row;
    q_op.q_col   = in_cmd.query_col;
    // reads outside the grid answer zero without touching memory
    q_op.q_ok  = (int'(in_cmd.query_row) < GRID_SIZE) && (int'(in_cmd.query_col) < GRID_SIZE);
    case (kind_t'(in_cmd.kind))
      K_PEN_UP: begin
        q_op.op  = OP_PEN;
        q_op.pen = 1'b0;
      end
      K_PEN_DOWN: begin
        q_op.op  = OP_PEN;
        q_op.pen = 1'b1;
      end
      K_FACE_RIGHT: begin
        q_op.op  = OP_FACE;
        q_op.hdg = H_RIGHT;
      end
      K_FACE_LEFT: begin
        q_op.op  = OP_FACE;
        q_op.hdg = H_LEFT;
      end
      K_FACE_UP: begin
        q_op.op  = OP_FACE;
        q_op.hdg = H_UP;
      end
      K_FACE_DOWN: begin
        q_op.op  = OP_FACE;
        q_op.hdg = H_DOWN;
      end
      K_MOVE: begin
        q_op.op = OP_MOVE;
      end
      K_READ: begin
        q_op.op = OP_READ;
      end
      default: begin
        q_op.op = OP_PEN;
      end
    endcase
  end

endmodule

// File: rtl/core/tsp_queue.sv
module tsp_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  tsp_pkg::cmd_op_t push_op,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output tsp_pkg::cmd_op_t pop_op
);
  import tsp_pkg::*;

  cmd_op_t           slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;

  assign full      = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_op    = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

// File: rtl/core/tsp_back.sv
module tsp_back #(
  parameter int GRID_SIZE = tsp_pkg::GRID_SIZE_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  tsp_pkg::cmd_op_t q_op,
  output tsp_pkg::bk_stat_t stat,
  tsp_res_if.source        out_res
);
  import tsp_pkg::*;

  localparam int POS_W = (GRID_SIZE > 1) ? $clog2(GRID_SIZE) : 1;
  localparam int SUM_W = ((POS_W > DIST_W) ? POS_W : DIST_W) + 1;

  bk_state_t state_r, state_nxt;

  logic [POS_W-1:0] row_r, row_nxt;
  logic [POS_W-1:0] col_r, col_nxt;
  logic             pen_r, pen_nxt;
  heading_t         hdg_r, hdg_nxt;

  // marking sweep: rows sweep_r..end_r each get mask_r ORed in
  logic [POS_W-1:0]     sweep_r, sweep_nxt;
  logic [POS_W-1:0]     end_r, end_nxt;
  logic [GRID_SIZE-1:0] mask_r, mask_nxt;
  logic [POS_W-1:0]     csel_r, csel_nxt;

  // per-row written flags stand in for clearing the grid at reset
  logic [GRID_SIZE-1:0] vld_r, vld_nxt;
  logic                 rd_vld_r, rd_vld_nxt;
  logic                 wr_pend_r, wr_pend_nxt;
  logic [POS_W-1:0]     wr_addr_r, wr_addr_nxt;

  logic                 rd_en;
  logic [POS_W-1:0]     rd_addr;
  logic [GRID_SIZE-1:0] rd_data;
  logic [GRID_SIZE-1:0] wr_data;

  logic                 out_valid_r, out_valid_nxt;
  logic [POS_OUT_W-1:0] out_row_r, out_row_nxt;
  logic [POS_OUT_W-1:0] out_col_r, out_col_nxt;
  logic                 out_pen_r, out_pen_nxt;
  heading_t             out_hdg_r, out_hdg_nxt;
  logic                 out_cell_r, out_cell_nxt;
  logic                 load_out;
  logic                 cell_val;

  logic                 out_free;
  logic                 pop;
  logic                 horiz;
  logic                 fwd;
  logic [POS_W-1:0]     from_pos;
  logic [SUM_W-1:0]     sum;
  logic [POS_W-1:0]     to_pos;
  logic [POS_W-1:0]     lo;
  logic [POS_W-1:0]     hi;
  logic [GRID_SIZE-1:0] range_mask;

  assign out_free  = !out_valid_r || out_res.ready;
  assign pop       = (state_r == BK_IDLE) && q_valid && out_free;
  assign stat.pop  = pop;
  assign stat.busy = (state_r != BK_IDLE);

  // move target, clamped at the grid edges
  assign horiz    = hdg_r inside {H_RIGHT, H_LEFT};
  assign fwd      = hdg_r inside {H_RIGHT, H_DOWN};
  assign from_pos = horiz ? col_r : row_r;
  assign sum      = SUM_W'(from_pos) + SUM_W'(q_op.mv_dist);

  always_comb begin
    if (fwd) begin
      to_pos = (sum > SUM_W'(GRID_SIZE-1)) ? POS_W'(GRID_SIZE-1) : POS_W'(sum);
    end else begin
      to_pos = (SUM_W'(q_op.mv_dist) > SUM_W'(from_pos)) ? '0
             : POS_W'(SUM_W'(from_pos) - SUM_W'(q_op.mv_dist));
    end
  end

  assign lo = (from_pos < to_pos) ? from_pos : to_pos;
  assign hi = (from_pos < to_pos) ? to_pos : from_pos;

  always_comb begin
    for (int i = 0; i < GRID_SIZE; i++) begin
      range_mask[i] = (POS_W'(i) >= lo) && (POS_W'(i) <= hi);
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (pop) begin
          if (q_op.op == OP_MOVE && pen_r) begin
            state_nxt = BK_MARK;
          end else if (q_op.op == OP_READ && q_op.q_ok) begin
            state_nxt = BK_READ;
          end
        end
      end
      BK_MARK: begin
        if (sweep_r == end_r) begin
          state_nxt = BK_DRAIN;
        end
      end
      BK_DRAIN: state_nxt = BK_IDLE;
      BK_READ:  state_nxt = BK_IDLE;
      default:  state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    row_nxt     = row_r;
    col_nxt     = col_r;
    pen_nxt     = pen_r;
    hdg_nxt     = hdg_r;
    sweep_nxt   = sweep_r;
    end_nxt     = end_r;
    mask_nxt    = mask_r;
    csel_nxt    = csel_r;
    wr_pend_nxt = 1'b0;
    wr_addr_nxt = wr_addr_r;
    rd_en       = 1'b0;
    rd_addr     = sweep_r;
    load_out    = 1'b0;
    cell_val    = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (pop) begin
          case (q_op.op)
            OP_PEN: begin
              pen_nxt  = q_op.pen;
              load_out = 1'b1;
            end
            OP_FACE: begin
              hdg_nxt  = q_op.hdg;
              load_out = 1'b1;
            end
            OP_MOVE: begin
              if (horiz) begin
                col_nxt   = to_pos;
                sweep_nxt = row_r;
                end_nxt   = row_r;
                mask_nxt  = range_mask;
              end else begin
                row_nxt   = to_pos;
                sweep_nxt = lo;
                end_nxt   = hi;
                mask_nxt  = GRID_SIZE'(1) << col_r;
              end
              load_out = !pen_r;
            end
            OP_READ: begin
              if (q_op.q_ok) begin
                rd_en    = 1'b1;
                rd_addr  = POS_W'(q_op.q_row);
                csel_nxt = POS_W'(q_op.q_col);
              end else begin
                load_out = 1'b1;
              end
            end
            default: load_out = 1'b1;
          endcase
        end
      end
      BK_MARK: begin
        // read row k while row k-1 is written back
        rd_en       = 1'b1;
        rd_addr     = sweep_r;
        wr_pend_nxt = 1'b1;
        wr_addr_nxt = sweep_r;
        sweep_nxt   = sweep_r + 1'b1;
      end
      BK_DRAIN: begin
        load_out = 1'b1;
      end
      BK_READ: begin
        load_out = 1'b1;
        cell_val = rd_vld_r && rd_data[csel_r];
      end
      default: ;
    endcase
  end

  assign rd_vld_nxt = rd_en ? vld_r[rd_addr] : rd_vld_r;
  assign wr_data    = (rd_vld_r ? rd_data : '0) | mask_r;

  always_comb begin
    vld_nxt = vld_r;
    if (wr_pend_r) begin
      vld_nxt[wr_addr_r] = 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;
    out_pen_nxt   = out_pen_r;
    out_hdg_nxt   = out_hdg_r;
    out_cell_nxt  = out_cell_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
      out_row_nxt   = POS_OUT_W'(row_nxt);
      out_col_nxt   = POS_OUT_W'(col_nxt);
      out_pen_nxt   = pen_nxt;
      out_hdg_nxt   = hdg_nxt;
      out_cell_nxt  = cell_val;
    end else if (out_res.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  tsp_ram #(
    .WIDTH (GRID_SIZE),
    .DEPTH (GRID_SIZE)
  ) u_grid (
    .clk   (clk),
    .we    (wr_pend_r),
    .waddr (wr_addr_r),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      row_r       <= '0;
      col_r       <= '0;
      pen_r       <= 1'b0;
      hdg_r       <= H_DOWN;
      vld_r       <= '0;
      wr_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      pen_r       <= pen_nxt;
      hdg_r       <= hdg_nxt;
      vld_r       <= vld_nxt;
      wr_pend_r   <= wr_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sweep_r    <= sweep_nxt;
    end_r      <= end_nxt;
    mask_r     <= mask_nxt;
    csel_r     <= csel_nxt;
    wr_addr_r  <= wr_addr_nxt;
    rd_vld_r   <= rd_vld_nxt;
    out_row_r  <= out_row_nxt;
    out_col_r  <= out_col_nxt;
    out_pen_r  <= out_pen_nxt;
    out_hdg_r  <= out_hdg_nxt;
    out_cell_r <= out_cell_nxt;
  end

  assign out_res.valid          = out_valid_r;
  assign out_res.cursor_row_out = out_row_r;
  assign out_res.cursor_col_out = out_col_r;
  assign out_res.pen_is_down    = out_pen_r;
  assign out_res.heading_out    = out_hdg_r;
  assign out_res.cell_bit       = out_cell_r;

endmodule

// File: rtl/core/turtle_stroke_plotter_top.sv
// Turtle-graphics plotter on a GRID_SIZE x GRID_SIZE bit grid, one result word per
// command word. Commands are decoded on entry and wait in a two-deep queue, so the
// input keeps taking words while the executor is busy until the queue is full. The
// executor owns the cursor, pen, heading and the grid, kept in a single-port-write,
// registered-read RAM with one row per entry. Pen, heading and pen-up moves, and
// a read of a cell outside the grid, finish in the idle state; an in-grid read
// goes through a read state for the registered RAM read. A pen-down move
// read-modify-writes one grid row per cycle, pipelined, in a marking state, then a
// drain state; it covers 1 row for a horizontal move and up to GRID_SIZE rows for a
// vertical one. The grid reads as cleared right after reset through per-row written
// flags; there is no clearing pass. Results sit in an output register and the
// executor starts the next command in the cycle that register is taken.
module turtle_stroke_plotter_top #(
  parameter int GRID_SIZE = tsp_pkg::GRID_SIZE_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  tsp_cmd_if.sink    in_cmd,
  tsp_res_if.source  out_res
);
  import tsp_pkg::*;

  logic     q_push;
  logic     q_full;
  logic     q_valid;
  cmd_op_t  push_op;
  cmd_op_t  pop_op;
  bk_stat_t bk_stat;

  tsp_front #(
    .GRID_SIZE (GRID_SIZE)
  ) u_front (
    .in_cmd (in_cmd),
    .q_full (q_full),
    .q_push (q_push),
    .q_op   (push_op)
  );

  tsp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_op   (push_op),
    .full      (q_full),
    .pop       (bk_stat.pop),
    .not_empty (q_valid),
    .pop_op    (pop_op)
  );

  tsp_back #(
    .GRID_SIZE (GRID_SIZE)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_op    (pop_op),
    .stat    (bk_stat),
    .out_res (out_res)
  );

`ifndef SYNTHESIS
  // executor never starts a command while an untaken result would be overwritten
  a_pop_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    bk_stat.pop |-> (!out_res.valid || out_res.ready))
    else $error("command started with output word still pending");

  // a started command either produced its word or is still running
  a_pop_progress: assert property (@(posedge clk) disable iff (!rst_n)
    bk_stat.pop |=> (out_res.valid || bk_stat.busy))
    else $error("command dropped without a result");

  // a new result only appears after a command was started or finished
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_res.valid) |-> ($past(bk_stat.pop) || $past(bk_stat.busy)))
    else $error("result word without a command");

  // input backpressure follows queue occupancy
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (q_full && !bk_stat.pop) |=> !(in_cmd.valid && in_cmd.ready && q_full && !bk_stat.pop))
    else $error("command accepted into a full queue");
`endif

endmodule
